// File: rtl/core/pss_pkg.sv
// Shared types and constants for the payload signature classifier.
// Used by the top level, the rule logic and the port checker; no dependencies.
`default_nettype none

package pss_pkg;

   localparam int CAPTURE_BYTES_DEF = 64;
   // Highest payload offset any rule looks at is 53.
   localparam int USED_BYTES        = 54;
   localparam int COUNT_W           = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [1:0] VERDICT_UNDECIDED = 2'd0;
   localparam logic [1:0] VERDICT_DETECTED  = 2'd1;
   localparam logic [1:0] VERDICT_EXCLUDED  = 2'd2;

   localparam logic [3:0] RULE_TCP_EQUAL    = 4'd0;
   localparam logic [3:0] RULE_TCP_CONST_A  = 4'd1;
   localparam logic [3:0] RULE_TCP_CONST_B  = 4'd2;
   localparam logic [3:0] RULE_TCP_LEN26    = 4'd3;
   localparam logic [3:0] RULE_TCP_LEN18    = 4'd4;
   localparam logic [3:0] RULE_TCP_PAIRS    = 4'd5;
   localparam logic [3:0] RULE_UDP_PREFIX   = 4'd6;
   localparam logic [3:0] RULE_UDP_TYPE     = 4'd7;
   localparam logic [3:0] RULE_UDP_REPEAT   = 4'd8;
   localparam logic [3:0] RULE_UDP_EQUAL    = 4'd9;
   localparam logic [3:0] RULE_NONE         = 4'd10;

   localparam logic MODE_TCP = 1'b0;
   localparam logic MODE_UDP = 1'b1;

   localparam int PREFIX_A_LEN = 7;
   localparam int PREFIX_B_LEN = 16;

   localparam logic [7:0] UDP_PREFIX_A [PREFIX_A_LEN] = '{
      8'h6f, 8'ha1, 8'h9d, 8'h59, 8'h97, 8'h4a, 8'h97
   };
   localparam logic [7:0] UDP_PREFIX_B [PREFIX_B_LEN] = '{
      8'h32, 8'h91, 8'h9d, 8'h59, 8'h30, 8'h1e, 8'h30, 8'h07,
      8'h30, 8'h0e, 8'h31, 8'h1f, 8'h18, 8'hf5, 8'h30, 8'h1e
   };

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [3:0] rule_hit;
   } rsp_payload_type;

endpackage

`default_nettype wire

// File: rtl/core/payload_signature_classifier.sv
// Top level of the payload signature classifier: request register, head byte
// store, byte count and result register. Depends on pss_pkg and pss_rules.
//
//   channel  direction  handshake             payload
//   req      in         req_valid / req_stall  pss_pkg::req_payload_type
//   rsp      out        rsp_valid / rsp_stall  pss_pkg::rsp_payload_type
//
// One request per cycle while req_stall is low. A request marked last gives its
// result through the request register and then the result register; other requests give none.
// The rule test is combinational and sits between the request register and the
// result register, on the stored bytes plus the byte being written.
// A stalled result holds; the request register keeps taking requests until a
// last-marked request finds the result register full and stalled.
// Reset (synchronous) clears the count and both valid flags; the byte store
// is not cleared, since the count masks bytes not yet written.
`default_nettype none

module payload_signature_classifier #(
   parameter int CAPTURE_BYTES = pss_pkg::CAPTURE_BYTES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire pss_pkg::req_payload_type  req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output pss_pkg::rsp_payload_type       rsp_payload
);
   import pss_pkg::*;

   localparam int IDX_W = $clog2(CAPTURE_BYTES);

   logic                  s1_valid_ff, s1_valid_in;
   req_payload_type       s1_req_ff, s1_req_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [7:0]            head_ff [CAPTURE_BYTES];
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   logic                  slot_free;
   logic                  s1_move;
   logic                  accept;
   logic                  fire;
   logic [COUNT_W-1:0]    len_new;
   logic [7:0]            win [USED_BYTES];
   rsp_payload_type       cls;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && (!s1_req_ff.last_byte || slot_free);
   assign req_stall = reset || (s1_valid_ff && !s1_move);
   assign accept    = req_valid && !req_stall;
   assign fire      = s1_move && s1_req_ff.last_byte;

   assign s1_valid_in = accept || (s1_valid_ff && !s1_move);
   assign s1_req_in   = accept ? req_payload : s1_req_ff;

   // Saturating length including the byte in the request register.
   assign len_new = (s1_req_ff.byte_valid && (count_ff != COUNT_MAX)) ?
                    count_ff + COUNT_W'(1) : count_ff;

   always_comb begin
      count_in = count_ff;
      if (s1_move) begin
         count_in = s1_req_ff.last_byte ? '0 : len_new;
      end
   end

   // Bypass the byte being written into the window the rules see.
   generate
      for (genvar g = 0; g < USED_BYTES; g++) begin : g_win
         assign win[g] = (s1_req_ff.byte_valid && (count_ff == COUNT_W'(g))) ?
                         s1_req_ff.data_byte : head_ff[g];
      end
   endgenerate

   pss_rules u_rules (
      .mode   (s1_req_ff.mode),
      .len    (len_new),
      .win    (win),
      .result (cls)
   );

   assign rsp_valid_in   = fire || (rsp_valid_ff && rsp_stall);
   assign rsp_payload_in = fire ? cls : rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff      <= s1_req_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (!reset && s1_move && s1_req_ff.byte_valid
          && (count_ff < COUNT_W'(CAPTURE_BYTES))) begin
         head_ff[count_ff[IDX_W-1:0]] <= s1_req_ff.data_byte;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// File: rtl/core/pss_rules.sv
// Signature rules: combinational test of the captured head bytes and length.
// Depends on pss_pkg.
`default_nettype none

module pss_rules (
   input  wire logic                          mode,
   input  wire logic [pss_pkg::COUNT_W-1:0]   len,
   input  wire logic [7:0]                    win [pss_pkg::USED_BYTES],
   output pss_pkg::rsp_payload_type           result
);
   import pss_pkg::*;

   logic [USED_BYTES-1:0] pr;
   logic [5:0]            tcp_hit;
   logic [3:0]            udp_hit;
   logic                  pfx_a;
   logic                  pfx_b;
   logic [3:0]            tcp_rule;
   logic [3:0]            udp_rule;

   function automatic logic is_v(input logic p, input logic [7:0] b, input logic [7:0] v);
      return p && (b == v);
   endfunction

   function automatic logic sm(input logic pa, input logic pb,
                               input logic [7:0] a, input logic [7:0] b);
      return pa && pb && (a == b);
   endfunction

   // A byte at or past the length never matches.
   always_comb begin
      for (int i = 0; i < USED_BYTES; i++) begin
         pr[i] = (len > COUNT_W'(i));
      end
   end

   always_comb begin
      pfx_a = 1'b1;
      for (int i = 0; i < PREFIX_A_LEN; i++) begin
         pfx_a = pfx_a & is_v(pr[i], win[i], UDP_PREFIX_A[i]);
      end
      pfx_b = 1'b1;
      for (int i = 0; i < PREFIX_B_LEN; i++) begin
         pfx_b = pfx_b & is_v(pr[i], win[i], UDP_PREFIX_B[i]);
      end
   end

   always_comb begin
      tcp_hit[0] = (len >= COUNT_W'(16)) && is_v(pr[3], win[3], 8'h00)
                   && sm(pr[4], pr[6], win[4], win[6])
                   && sm(pr[4], pr[10], win[4], win[10]);
      tcp_hit[1] = (len >= COUNT_W'(50)) && is_v(pr[41], win[41], 8'h00)
                   && is_v(pr[48], win[48], 8'h10) && is_v(pr[49], win[49], 8'h18)
                   && is_v(pr[50], win[50], 8'h0a);
      tcp_hit[2] = (len >= COUNT_W'(50)) && is_v(pr[41], win[41], 8'h00)
                   && is_v(pr[48], win[48], 8'he0) && is_v(pr[49], win[49], 8'h00)
                   && is_v(pr[50], win[50], 8'h0a);
      tcp_hit[3] = (len == COUNT_W'(26)) && is_v(pr[14], win[14], 8'h00)
                   && is_v(pr[15], win[15], 8'h00) && is_v(pr[21], win[21], 8'h00)
                   && is_v(pr[22], win[22], 8'h00) && is_v(pr[24], win[24], 8'h00)
                   && is_v(pr[25], win[25], 8'h00);
      tcp_hit[4] = (len == COUNT_W'(18)) && pr[1]
                   && (win[1] >= 8'h91) && (win[1] <= 8'h9f)
                   && is_v(pr[14], win[14], 8'h00) && is_v(pr[15], win[15], 8'h00);
      tcp_hit[5] = (len == COUNT_W'(54))
                   || (is_v(pr[14], win[14], 8'h57) && is_v(pr[15], win[15], 8'h83)
                       && is_v(pr[22], win[22], 8'h78) && is_v(pr[23], win[23], 8'h38))
                   || (is_v(pr[46], win[46], 8'h6a) && is_v(pr[47], win[47], 8'hc1)
                       && is_v(pr[52], win[52], 8'h41) && is_v(pr[53], win[53], 8'h3a));

      udp_hit[0] = (len >= COUNT_W'(16)) && (pfx_a || pfx_b);
      udp_hit[1] = (len >= COUNT_W'(43))
                   && (is_v(pr[2], win[2], 8'h37) || is_v(pr[2], win[2], 8'h42))
                   && is_v(pr[3], win[3], 8'h59)
                   && is_v(pr[32], win[32], 8'h00) && is_v(pr[33], win[33], 8'h00)
                   && (is_v(pr[34], win[34], 8'h40) || is_v(pr[34], win[34], 8'h00))
                   && is_v(pr[35], win[35], 8'h00);
      udp_hit[2] = (len >= COUNT_W'(25)) && is_v(pr[2], win[2], 8'h42)
                   && is_v(pr[3], win[3], 8'h59)
                   && sm(pr[5], pr[21], win[5], win[21]) && sm(pr[6], pr[22], win[6], win[22])
                   && sm(pr[7], pr[23], win[7], win[23]) && sm(pr[8], pr[24], win[8], win[24])
                   && sm(pr[5], pr[24], win[5], win[24]);
      udp_hit[3] = (len >= COUNT_W'(25))
                   && sm(pr[4], pr[6], win[4], win[6]) && sm(pr[4], pr[8], win[4], win[8])
                   && sm(pr[4], pr[14], win[4], win[14]) && sm(pr[4], pr[18], win[4], win[18])
                   && sm(pr[4], pr[22], win[4], win[22]) && sm(pr[4], pr[24], win[4], win[24]);
   end

   // First hit wins.
   always_comb begin
      if (tcp_hit[0])      tcp_rule = RULE_TCP_EQUAL;
      else if (tcp_hit[1]) tcp_rule = RULE_TCP_CONST_A;
      else if (tcp_hit[2]) tcp_rule = RULE_TCP_CONST_B;
      else if (tcp_hit[3]) tcp_rule = RULE_TCP_LEN26;
      else if (tcp_hit[4]) tcp_rule = RULE_TCP_LEN18;
      else if (tcp_hit[5]) tcp_rule = RULE_TCP_PAIRS;
      else                 tcp_rule = RULE_NONE;

      if (udp_hit[0])      udp_rule = RULE_UDP_PREFIX;
      else if (udp_hit[1]) udp_rule = RULE_UDP_TYPE;
      else if (udp_hit[2]) udp_rule = RULE_UDP_REPEAT;
      else if (udp_hit[3]) udp_rule = RULE_UDP_EQUAL;
      else                 udp_rule = RULE_NONE;
   end

   always_comb begin
      if (mode == MODE_TCP) begin
         result.rule_hit = tcp_rule;
         result.verdict  = (tcp_rule == RULE_NONE) ? VERDICT_EXCLUDED : VERDICT_DETECTED;
      end else begin
         result.rule_hit = udp_rule;
         result.verdict  = (udp_rule == RULE_NONE) ? VERDICT_UNDECIDED : VERDICT_DETECTED;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/pss_checker.sv
// Port-level checks for the payload signature classifier, bound to the top.
// Depends on pss_pkg.
`default_nettype none

module pss_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire pss_pkg::req_payload_type  req_payload,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire pss_pkg::rsp_payload_type  rsp_payload
);
   import pss_pkg::*;

   // Stalled result must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // Detected exactly when some rule hit.
   a_verdict_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.verdict == VERDICT_DETECTED)
                     == (rsp_payload.rule_hit != RULE_NONE)))
      else $error("verdict and rule disagree");

   // Excluded only comes from a TCP miss, so it always pairs with no rule.
   a_excluded_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.verdict == VERDICT_EXCLUDED)
      |-> rsp_payload.rule_hit == RULE_NONE)
      else $error("excluded verdict with a rule hit");

   // A new result comes from a last-marked request, taken through the request register.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_payload.last_byte, 2))
      else $error("result without a last-marked request");

endmodule

bind payload_signature_classifier pss_checker u_pss_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
